// ===== design/battery_thermal_charge_guard_top_assert.svh =====
// Assertion macros for the battery thermal charge guard.
`ifndef BATTERY_THERMAL_CHARGE_GUARD_TOP_ASSERT_SVH
`define BATTERY_THERMAL_CHARGE_GUARD_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define BTCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btcg assertion failed");
// Checked on every clock edge, reset included.
`define BTCG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("btcg assertion failed");
`else
`define BTCG_ASSERT(lbl, prop)
`define BTCG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/btcg_pkg.sv =====
// Types and constants of the battery thermal charge guard.
`timescale 1ns / 1ps
package btcg_pkg;

  localparam int unsigned TempW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CUTOFF_LOW   = 3'd0,
    CFG_CUTOFF_HIGH  = 3'd1,
    CFG_PAUSE_LOW    = 3'd2,
    CFG_PAUSE_HIGH   = 3'd3,
    CFG_RESUME_LOW   = 3'd4,
    CFG_RESUME_HIGH  = 3'd5,
    CFG_CUTOFF_LIMIT = 3'd6,
    CFG_DONE_LIMIT   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_IDLE  = 2'd0,
    STATUS_FAST  = 2'd1,
    STATUS_DONE  = 2'd2,
    STATUS_ERROR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_PAUSED  = 2'd1,
    MARK_RESUMED = 2'd2
  } mark_e;

  // Register reset values
  localparam logic [TempW-1:0]  CutoffLowRst   = 16'd237;
  localparam logic [TempW-1:0]  CutoffHighRst  = 16'd870;
  localparam logic [TempW-1:0]  PauseLowRst    = 16'd337;
  localparam logic [TempW-1:0]  PauseHighRst   = 16'd748;
  localparam logic [TempW-1:0]  ResumeLowRst   = 16'd353;
  localparam logic [TempW-1:0]  ResumeHighRst  = 16'd730;
  localparam logic [CountW-1:0] CutoffLimitRst = 8'd3;
  localparam logic [CountW-1:0] DoneLimitRst   = 8'd2;

  typedef struct packed {
    logic             opcode;
    logic             adapter_present;
    logic [TempW-1:0] temperature_reading;
    logic             device_on;
    logic             done_pin_level;
  } in_t;

  typedef struct packed {
    logic       power_off_request;
    logic       charging_blocked;
    logic [1:0] status_code;
  } out_t;

  // Saturating increment of an event counter
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == {CountW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/btcg_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface btcg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/battery_thermal_charge_guard_top.sv =====
// Top level of the battery thermal charge guard.
// Each input item (a temperature evaluation or a charge status query) gives a single
// result, which appears in the output register in the cycle after its transfer; a new
// item is accepted every cycle as long as the output register is empty or being drained
// in the same cycle, so the sustained rate is one item per clock. The rate holds because
// the counters, pause mark and charge-disable drive are updated from combinational
// next-state logic together with the result register. Configuration registers are
// written through the write port and take effect for the next accepted item.
`timescale 1ns / 1ps
`include "battery_thermal_charge_guard_top_assert.svh"
module battery_thermal_charge_guard_top
  import btcg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  btcg_stream_if.sink         in_i,
  btcg_stream_if.source       out_o
);

  // Configuration registers
  logic [TempW-1:0]  cut_low_q, cut_high_q, pause_low_q, pause_high_q;
  logic [TempW-1:0]  res_low_q, res_high_q;
  logic [CountW-1:0] cut_limit_q, done_limit_q;

  // Guard state
  logic [CountW-1:0] unpl_cnt_q, unpl_cnt_d;
  logic [CountW-1:0] plug_cnt_q, plug_cnt_d;
  logic [CountW-1:0] done_cnt_q, done_cnt_d;
  mark_e             mark_q, mark_d;
  logic              drive_q, drive_d;

  // Output register
  logic out_valid_q;
  out_t out_q, out_d;

  logic in_xfer;
  in_t  item;
  logic cutoff, pause_zone, resume_band;

  assign item     = in_i.payload;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_low_q    <= CutoffLowRst;
      cut_high_q   <= CutoffHighRst;
      pause_low_q  <= PauseLowRst;
      pause_high_q <= PauseHighRst;
      res_low_q    <= ResumeLowRst;
      res_high_q   <= ResumeHighRst;
      cut_limit_q  <= CutoffLimitRst;
      done_limit_q <= DoneLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF_LOW:   cut_low_q    <= cfg_data_i;
        CFG_CUTOFF_HIGH:  cut_high_q   <= cfg_data_i;
        CFG_PAUSE_LOW:    pause_low_q  <= cfg_data_i;
        CFG_PAUSE_HIGH:   pause_high_q <= cfg_data_i;
        CFG_RESUME_LOW:   res_low_q    <= cfg_data_i;
        CFG_RESUME_HIGH:  res_high_q   <= cfg_data_i;
        CFG_CUTOFF_LIMIT: cut_limit_q  <= cfg_data_i[CountW-1:0];
        CFG_DONE_LIMIT:   done_limit_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Zone decode of the reading
  assign cutoff      = (item.temperature_reading <= cut_low_q) ||
                       (item.temperature_reading >= cut_high_q);
  assign pause_zone  = (item.temperature_reading <= pause_low_q) ||
                       (item.temperature_reading >= pause_high_q);
  assign resume_band = (item.temperature_reading >= res_low_q) &&
                       (item.temperature_reading <= res_high_q);

  // Next state and result for the item on the input
  always_comb begin
    unpl_cnt_d = unpl_cnt_q;
    plug_cnt_d = plug_cnt_q;
    done_cnt_d = done_cnt_q;
    mark_d     = mark_q;
    drive_d    = drive_q;
    out_d.power_off_request = 1'b0;
    out_d.status_code       = STATUS_IDLE;

    if (item.opcode == OP_EVAL) begin
      if (!item.adapter_present) begin
        unpl_cnt_d = cutoff ? sat_inc(unpl_cnt_q) : '0;
        out_d.power_off_request = (unpl_cnt_d >= cut_limit_q);
      end else begin
        if (cutoff) begin
          plug_cnt_d = sat_inc(plug_cnt_q);
        end else begin
          plug_cnt_d = '0;
          if (pause_zone) begin
            if (mark_q != MARK_PAUSED) begin
              drive_d = 1'b1;
              mark_d  = MARK_PAUSED;
            end
          end else if (resume_band && (mark_q == MARK_PAUSED)) begin
            // hysteresis: only a paused charger resumes inside the band
            mark_d  = MARK_RESUMED;
            drive_d = 1'b0;
          end
        end
        if (plug_cnt_d >= cut_limit_q) begin
          drive_d = 1'b1;
          if (item.device_on) begin
            out_d.power_off_request = 1'b1;
            mark_d = MARK_PAUSED;
          end
        end
      end
    end else if (item.adapter_present) begin
      if (!item.done_pin_level) begin
        done_cnt_d = '0;
        out_d.status_code = STATUS_FAST;
      end else if (done_cnt_q >= done_limit_q) begin
        done_cnt_d = '0;
        out_d.status_code = STATUS_DONE;
      end else begin
        done_cnt_d = sat_inc(done_cnt_q);
      end
      if (mark_q == MARK_PAUSED) begin
        out_d.status_code = STATUS_ERROR;
      end
    end

    out_d.charging_blocked = drive_d;
  end

  // State update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unpl_cnt_q <= '0;
      plug_cnt_q <= '0;
      done_cnt_q <= '0;
      mark_q     <= MARK_NONE;
      drive_q    <= 1'b0;
    end else if (in_xfer) begin
      unpl_cnt_q <= unpl_cnt_d;
      plug_cnt_q <= plug_cnt_d;
      done_cnt_q <= done_cnt_d;
      mark_q     <= mark_d;
      drive_q    <= drive_d;
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  // Every input transfer leaves a result waiting in the output register
  `BTCG_ASSERT(a_xfer_gives_result, in_xfer |=> out_valid_q)
  // The reported blocking level follows the charge-disable drive
  `BTCG_ASSERT(a_blocked_matches_drive, in_xfer |=> (out_q.charging_blocked == drive_q))
  // A paused charger always has the disable drive asserted
  `BTCG_ASSERT_ALWAYS(a_paused_blocks, (mark_q == MARK_PAUSED) |-> drive_q)
  // Status results never carry a power-off request
  `BTCG_ASSERT(a_status_no_poff,
               (out_valid_q && (out_q.status_code != STATUS_IDLE)) |->
               !out_q.power_off_request)
  // Without a transfer the guard state holds
  `BTCG_ASSERT(a_state_holds,
               !in_xfer |=> ($stable(plug_cnt_q) && $stable(unpl_cnt_q) &&
                             $stable(done_cnt_q) && $stable(drive_q)))

endmodule
